>>> src/swng_pkg.sv
// ----------------------------------------------------------------------------
// swng_pkg: shared definitions for the seeded weight noise generator
// Operation and format codes, generator constants and float packing.
// ----------------------------------------------------------------------------
package swng_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned FmtW   = 2;
  localparam int unsigned SeedW  = 64;
  localparam int unsigned IdW    = 32;
  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 3;
  localparam int unsigned PaddrW = 4;

  localparam logic [OpW-1:0] OP_RESEED  = 2'd0;
  localparam logic [OpW-1:0] OP_PAYLOAD = 2'd1;
  localparam logic [OpW-1:0] OP_SCALE   = 2'd2;

  localparam logic [FmtW-1:0] FMT_RAW  = 2'd0;
  localparam logic [FmtW-1:0] FMT_FP32 = 2'd1;

  localparam logic [63:0] NOISE_MULT     = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] KIND_MULT      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] LAYER_MULT     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] FALLBACK_STATE = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SEED_RESET     = 64'd1;

  localparam logic [7:0]  SCALE_BASE  = 8'd120;
  localparam logic [4:0]  SHIFT_FP32  = 5'd18;
  localparam logic [4:0]  SHIFT_BF16  = 5'd20;
  localparam logic [15:0] K_OFFSET    = 16'h8000;

  localparam logic [BytesW-1:0] BYTES_ONE  = 3'd1;
  localparam logic [BytesW-1:0] BYTES_TWO  = 3'd2;
  localparam logic [BytesW-1:0] BYTES_FOUR = 3'd4;

  // Low 64 bits of a 64-bit constant times a 32-bit value, in 32-bit halves.
  function automatic logic [63:0] mul_c64(logic [63:0] c, logic [31:0] v);
    logic [63:0] lo_prod;
    logic [31:0] hi_prod;
    begin
      lo_prod = {32'd0, c[31:0]} * {32'd0, v};
      hi_prod = c[63:32] * v;
      mul_c64 = lo_prod + {hi_prod, 32'd0};
    end
  endfunction

  // Binary32 bits of (low - 32768) * 2^-shift, exact.
  function automatic logic [31:0] scaled_bits(logic [15:0] low, logic [4:0] shift);
    logic        sign;
    logic [15:0] mag;
    logic [4:0]  msb;
    logic [7:0]  expo;
    logic [23:0] sh;
    begin
      sign = (low < K_OFFSET);
      mag  = sign ? (K_OFFSET - low) : (low - K_OFFSET);
      msb  = 5'd0;
      for (int i = 0; i < 16; i++) begin
        if (mag[i]) msb = 5'(i);
      end
      expo = 8'(msb) + 8'd127 - 8'(shift);
      sh   = {8'd0, mag} << (5'd23 - msb);
      if (low == K_OFFSET) scaled_bits = 32'd0;
      else scaled_bits = {sign, expo, sh[22:0]};
    end
  endfunction

endpackage

>>> src/seeded_weight_noise_generator.sv
// ----------------------------------------------------------------------------
// seeded_weight_noise_generator
// Reproducible xorshift64* pattern source for weight tensor elements.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i / in_stall_o, elements leave on
// out_valid_o / out_stall_i. A reseed item loads the generator from
// base_seed, tensor kind and layer index and gives no element; payload and
// scale items each step the generator and give one element.
// After an item is accepted it passes one input register, then the generator
// step and element packing into the output register raise out_valid_o.
// Throughput is one item per cycle while the receiver does not stall, bounded
// by the single generator state register that every item updates.
// The output only needs the low 16 bits of the 64-bit product, so a
// 16x16 multiply serves; reseed uses split 32-bit constant multiplies.
// When the receiver stalls, the output register holds and the input stage
// fills; in_stall_o rises only once an element-producing item is waiting.
// Reset sets base_seed to 1 and the state to 0x2545f4914f6cdd1d.
// base_seed is written through the APB port at addresses 0 to 7 (paddr[3] clear, 64-bit data).
module seeded_weight_noise_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swng_pkg::PaddrW-1:0]  paddr,
  input  logic [swng_pkg::SeedW-1:0]   pwdata,
  output logic [swng_pkg::SeedW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [swng_pkg::OpW-1:0]     operation_i,
  input  logic [swng_pkg::IdW-1:0]     tensor_kind_i,
  input  logic [swng_pkg::IdW-1:0]     layer_index_i,
  input  logic [swng_pkg::FmtW-1:0]    element_format_i,
  input  logic                         final_element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [swng_pkg::WordW-1:0]   data_word_o,
  output logic [swng_pkg::BytesW-1:0]  data_bytes_o,
  output logic                         last_o
);
  import swng_pkg::*;

  logic [SeedW-1:0]  seed_q, state_q, state_d;
  logic              s1_valid_q;
  logic [OpW-1:0]    s1_op_q;
  logic [IdW-1:0]    s1_kind_q, s1_layer_q;
  logic [FmtW-1:0]   s1_fmt_q;
  logic              s1_last_q;
  logic              out_valid_q, out_last_q;
  logic [WordW-1:0]  out_word_q, word_d, bf_bits;
  logic [BytesW-1:0] out_bytes_q, bytes_d;

  logic out_free, s1_emits, s1_move, in_take;
  logic [SeedW-1:0] x1, x2, x3, mixed;
  logic [15:0] noise_lo;

  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1] == 1'b0) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr[PaddrW-1] == 1'b0) begin
      seed_q <= pwdata;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_emits = (s1_op_q == OP_PAYLOAD) || (s1_op_q == OP_SCALE);
  assign s1_move  = s1_valid_q && (!s1_emits || out_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take  = in_valid_i && !in_stall_o;

  // Generator step and reseed mix
  always_comb begin
    x1 = state_q ^ (state_q >> 12);
    x2 = x1 ^ (x1 << 25);
    x3 = x2 ^ (x2 >> 27);
    noise_lo = x3[15:0] * NOISE_MULT[15:0];
    mixed = seed_q ^ mul_c64(KIND_MULT, s1_kind_q) ^ mul_c64(LAYER_MULT, s1_layer_q);
    state_d = state_q;
    if (s1_move) begin
      if (s1_op_q == OP_RESEED) state_d = (mixed == '0) ? FALLBACK_STATE : mixed;
      else if (s1_emits) state_d = x3;
    end
  end

  always_comb begin
    word_d  = '0;
    bytes_d = BYTES_ONE;
    bf_bits = scaled_bits(noise_lo, SHIFT_BF16);
    if (s1_op_q == OP_SCALE) begin
      word_d = {24'd0, SCALE_BASE + {5'd0, noise_lo[2:0]}};
    end else if (s1_fmt_q == FMT_RAW) begin
      word_d = {24'd0, noise_lo[7:0]};
    end else if (s1_fmt_q == FMT_FP32) begin
      word_d  = scaled_bits(noise_lo, SHIFT_FP32);
      bytes_d = BYTES_FOUR;
    end else begin
      word_d  = {16'd0, bf_bits[31:16]};
      bytes_d = BYTES_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FALLBACK_STATE;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) s1_valid_q <= 1'b1;
      else if (s1_move) s1_valid_q <= 1'b0;
      if (s1_move && s1_emits) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q    <= operation_i;
      s1_kind_q  <= tensor_kind_i + 32'd1;
      s1_layer_q <= layer_index_i + 32'd1;
      s1_fmt_q   <= element_format_i;
      s1_last_q  <= final_element_i;
    end
    if (s1_move && s1_emits) begin
      out_word_q  <= word_d;
      out_bytes_q <= bytes_d;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_word_o  = out_word_q;
  assign data_bytes_o = out_bytes_q;
  assign last_o       = out_last_q;

endmodule
